/* hw/rtl/cmc_pkg.sv */
// cooling mode controller package: mode type, decision codes, register map and reset values
// used by cmc_cfg_regs and cooling_mode_controller; depends on nothing
`default_nettype none

package cmc_pkg;

    // default width of the timestamps kept inside the block
    localparam int TIME_WIDTH_DEF = 63;

    // one-hot mode state
    typedef enum logic [4:0] {
        MODE_OFF  = 5'b00001,
        MODE_FAN  = 5'b00010,
        MODE_LOW  = 5'b00100,
        MODE_MED  = 5'b01000,
        MODE_HIGH = 5'b10000
    } t_mode;

    // mode codes as seen on the result beat
    localparam logic [2:0] CODE_OFF  = 3'd0;
    localparam logic [2:0] CODE_FAN  = 3'd1;
    localparam logic [2:0] CODE_LOW  = 3'd2;
    localparam logic [2:0] CODE_MED  = 3'd3;
    localparam logic [2:0] CODE_HIGH = 3'd4;

    // decision codes
    localparam logic [1:0] DEC_STAY     = 2'd0;
    localparam logic [1:0] DEC_SWITCHED = 2'd1;
    localparam logic [1:0] DEC_DEBOUNCE = 2'd2;
    localparam logic [1:0] DEC_BACKOFF  = 2'd3;

    // request kinds
    localparam logic REQ_EVAL   = 1'b0;
    localparam logic REQ_ADJUST = 1'b1;

    // register indexes (byte address is 8 times the index)
    localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
    localparam logic [2:0] REG_COOL_CYCLE = 3'd1;
    localparam logic [2:0] REG_FAN        = 3'd2;
    localparam logic [2:0] REG_BACKOFF    = 3'd3;
    localparam logic [2:0] REG_DEADBAND   = 3'd4;
    localparam logic [2:0] REG_GENTLE     = 3'd5;
    localparam logic [2:0] REG_HYST       = 3'd6;

    localparam int ADDR_WIDTH = 6;
    localparam int DATA_WIDTH = 64;

    // register reset values
    localparam logic [39:0] DEBOUNCE_RST   = 40'd60000000;
    localparam logic [39:0] COOL_CYCLE_RST = 40'd3600000000;
    localparam logic [39:0] FAN_RST        = 40'd180000000;
    localparam logic [39:0] BACKOFF_RST    = 40'd900000000;
    localparam logic [10:0] DEADBAND_RST   = 11'd300;
    localparam logic [10:0] GENTLE_RST     = 11'd100;
    localparam logic [9:0]  HYST_RST       = 10'd25;

    // target limits in hundredths
    localparam logic [11:0] TGT_MIN   = 12'd2000;
    localparam logic [11:0] TGT_MAX   = 12'd4000;
    localparam logic [11:0] TGT_RESET = 12'd2900;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [39:0] debounce_time;
        logic [39:0] cool_cycle_time;
        logic [39:0] fan_time;
        logic [39:0] backoff_time;
        logic [10:0] start_margin;
        logic [10:0] soft_margin;
        logic [9:0]  gentle_hysteresis;
    } t_cfg;

    function automatic logic compressor_on(input t_mode m);
        logic r;
        case (m) inside
            MODE_LOW, MODE_MED, MODE_HIGH: r = 1'b1;
            default:                       r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_OFF:  c = CODE_OFF;
            MODE_FAN:  c = CODE_FAN;
            MODE_LOW:  c = CODE_LOW;
            MODE_MED:  c = CODE_MED;
            MODE_HIGH: c = CODE_HIGH;
            default:   c = CODE_OFF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/cmc_cfg_regs.sv */
// cooling mode controller register file behind an apb-style port
// depends on cmc_pkg for the register map, reset values and the t_cfg struct
`default_nettype none

module cmc_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cmc_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [cmc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [cmc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    output cmc_pkg::t_cfg                      o_cfg
);

    cmc_pkg::t_cfg r_cfg;
    logic [2:0]    s_index;
    logic          s_wr;

    assign pready  = 1'b1;
    assign s_index = paddr[5:3];
    assign s_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_time     <= cmc_pkg::DEBOUNCE_RST;
            r_cfg.cool_cycle_time   <= cmc_pkg::COOL_CYCLE_RST;
            r_cfg.fan_time          <= cmc_pkg::FAN_RST;
            r_cfg.backoff_time      <= cmc_pkg::BACKOFF_RST;
            r_cfg.start_margin      <= cmc_pkg::DEADBAND_RST;
            r_cfg.soft_margin       <= cmc_pkg::GENTLE_RST;
            r_cfg.gentle_hysteresis <= cmc_pkg::HYST_RST;
        end else if (s_wr) begin
            unique case (s_index)
                cmc_pkg::REG_DEBOUNCE:   r_cfg.debounce_time     <= pwdata[39:0];
                cmc_pkg::REG_COOL_CYCLE: r_cfg.cool_cycle_time   <= pwdata[39:0];
                cmc_pkg::REG_FAN:        r_cfg.fan_time          <= pwdata[39:0];
                cmc_pkg::REG_BACKOFF:    r_cfg.backoff_time      <= pwdata[39:0];
                cmc_pkg::REG_DEADBAND:   r_cfg.start_margin      <= pwdata[10:0];
                cmc_pkg::REG_GENTLE:     r_cfg.soft_margin       <= pwdata[10:0];
                cmc_pkg::REG_HYST:       r_cfg.gentle_hysteresis <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // read mux, unused index reads zero
    always_comb begin
        unique case (s_index)
            cmc_pkg::REG_DEBOUNCE:   prdata = {24'd0, r_cfg.debounce_time};
            cmc_pkg::REG_COOL_CYCLE: prdata = {24'd0, r_cfg.cool_cycle_time};
            cmc_pkg::REG_FAN:        prdata = {24'd0, r_cfg.fan_time};
            cmc_pkg::REG_BACKOFF:    prdata = {24'd0, r_cfg.backoff_time};
            cmc_pkg::REG_DEADBAND:   prdata = {53'd0, r_cfg.start_margin};
            cmc_pkg::REG_GENTLE:     prdata = {53'd0, r_cfg.soft_margin};
            cmc_pkg::REG_HYST:       prdata = {54'd0, r_cfg.gentle_hysteresis};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* hw/rtl/cooling_mode_controller.sv */
// cooling mode controller top level: input register, mode decision logic, result register
// depends on cmc_pkg and cmc_cfg_regs
`default_nettype none

// usage
//   s_axis carries requests: tuser picks the kind (0 evaluate with a humidex
//   sample, 1 adjust target), tdata holds timestamp, sample and target step.
//   m_axis returns one beat per request: mode after the request, the decision
//   (stay, switched, blocked by debounce, blocked by backoff) and the target.
//   the apb-style port holds seven registers at byte addresses 0, 8, .. 48;
//   write them only while no request is in flight.
// timing
//   an accepted request beat waits in the input register, then passes through the
//   decision logic into the result register. one request per cycle is sustained
//   while m_axis_tready stays high; the limit is the single pass from the input
//   register through the timestamp subtract-and-compare checks into the state
//   and result registers.
// reset and stall
//   synchronous active-low reset empties both registers, sets mode off, target
//   29.00 Hdx and the registers to their defaults. while m_axis_tready is low
//   the result beat holds and the input register still takes one more request;
//   s_axis_tready drops only when both are full.
module cooling_mode_controller #(
    parameter int TIME_WIDTH = cmc_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [62:0] now_time, [78:63] humidex sample, [90:79] target_step, [95:91] zero
    input  wire logic [95:0]                   s_axis_tdata,
    // [0] req_type
    input  wire logic [0:0]                    s_axis_tuser,
    // result channel
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [2:0] ac_mode, [4:3] decision, [16:5] target_now, [23:17] zero
    output logic      [23:0]                   m_axis_tdata,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cmc_pkg::ADDR_WIDTH-1:0] paddr,
    input  wire logic [cmc_pkg::DATA_WIDTH-1:0] pwdata,
    output logic      [cmc_pkg::DATA_WIDTH-1:0] prdata,
    output logic                               pready
);

    localparam int TW = TIME_WIDTH;

    cmc_pkg::t_cfg s_cfg;

    cmc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    // signed modular elapsed time reaches limit; negative elapsed never does
    function automatic logic reached(input logic [TW-1:0] now, input logic [TW-1:0] start,
                                     input logic [39:0] limit);
        logic [TW-1:0] d;
        d = now - start;
        return !d[TW-1] && (64'(d) >= 64'(limit));
    endfunction

    // input register
    logic                  r_in_valid;
    logic                  r_in_req;
    logic [TW-1:0]         r_in_time;
    logic signed [15:0]    r_in_fl;
    logic signed [11:0]    r_in_step;

    // result register
    logic                  r_out_valid;
    logic [23:0]           r_out_data;

    // controller state
    cmc_pkg::t_mode        r_mode, n_mode;
    logic [TW-1:0]         r_mea, n_mea;          // mode entered at
    logic [TW-1:0]         r_cstart, n_cstart;    // cooling started at
    logic [TW-1:0]         r_cend, n_cend;        // cooling ended at
    logic                  r_phase, n_phase;
    logic                  r_armed, n_armed;
    logic                  r_started, n_started;
    logic [11:0]           r_target, n_target;

    logic                  s_adv;
    logic [1:0]            s_dec;

    // effective state after the first-evaluate start
    cmc_pkg::t_mode        e_mode;
    logic [TW-1:0]         e_mea;
    logic [TW-1:0]         e_cend;
    logic                  e_phase;
    logic                  e_armed;

    logic signed [16:0]    s_delta;
    logic [11:0]           s_gh;
    logic                  s_cycle_over;
    cmc_pkg::t_mode        s_desired;
    logic signed [13:0]    s_tsum;

    // advance when the input register holds a request and the result slot frees
    assign s_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || s_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_req  <= s_axis_tuser[0];
            r_in_time <= s_axis_tdata[TW-1:0];
            r_in_fl   <= s_axis_tdata[78:63];
            r_in_step <= s_axis_tdata[90:79];
        end
    end

    // first evaluate starts the block from off with cleared cooling history
    always_comb begin
        e_mode  = r_started ? r_mode : cmc_pkg::MODE_OFF;
        e_mea   = r_started ? r_mea : r_in_time;
        e_cend  = r_started ? r_cend : '0;
        e_phase = r_started && r_phase;
        e_armed = r_started && r_armed;
    end

    assign s_delta = 17'(r_in_fl) - $signed({5'd0, r_target});
    assign s_gh    = {1'b0, s_cfg.soft_margin} + {2'b0, s_cfg.gentle_hysteresis};
    assign s_tsum  = $signed({2'b0, r_target}) + 14'(r_in_step);

    // cycle limit; with no cycle running it only fires for a zero limit
    assign s_cycle_over = e_phase ? reached(r_in_time, r_cstart, s_cfg.cool_cycle_time)
                                  : (s_cfg.cool_cycle_time == 40'd0);

    // desired mode from the sample
    always_comb begin
        s_desired = e_mode;
        unique case (e_mode)
            cmc_pkg::MODE_OFF: begin
                if (s_delta > $signed({6'd0, s_cfg.start_margin}))
                    s_desired = cmc_pkg::MODE_HIGH;
            end
            cmc_pkg::MODE_HIGH: begin
                if (s_cycle_over)
                    s_desired = cmc_pkg::MODE_FAN;
                else if (s_delta <= $signed({6'd0, s_cfg.soft_margin}))
                    s_desired = cmc_pkg::MODE_LOW;
            end
            cmc_pkg::MODE_LOW: begin
                if (s_delta > $signed({5'd0, s_gh}))
                    s_desired = cmc_pkg::MODE_HIGH;
                else if (s_delta <= 17'sd0 || s_cycle_over)
                    s_desired = cmc_pkg::MODE_FAN;
            end
            cmc_pkg::MODE_FAN: begin
                if (reached(r_in_time, e_mea, s_cfg.fan_time))
                    s_desired = cmc_pkg::MODE_OFF;
            end
            default: ; // cool medium has no rules
        endcase
    end

    // next state and decision
    always_comb begin
        n_mode    = r_mode;
        n_mea     = r_mea;
        n_cstart  = r_cstart;
        n_cend    = r_cend;
        n_phase   = r_phase;
        n_armed   = r_armed;
        n_started = r_started;
        n_target  = r_target;
        s_dec     = cmc_pkg::DEC_STAY;

        if (r_in_req == cmc_pkg::REQ_ADJUST) begin
            if (s_tsum < $signed({2'b0, cmc_pkg::TGT_MIN}))
                n_target = cmc_pkg::TGT_MIN;
            else if (s_tsum > $signed({2'b0, cmc_pkg::TGT_MAX}))
                n_target = cmc_pkg::TGT_MAX;
            else
                n_target = s_tsum[11:0];
            // debounce counts as already run out
            if (r_started)
                n_mea = TW'(64'(r_in_time) - 64'(s_cfg.debounce_time));
        end else begin
            n_started = 1'b1;
            n_mode    = e_mode;
            n_mea     = e_mea;
            n_cend    = e_cend;
            n_phase   = e_phase;
            n_armed   = e_armed;
            if (cmc_pkg::compressor_on(s_desired) && !cmc_pkg::compressor_on(e_mode) && e_armed
                && !reached(r_in_time, e_cend, s_cfg.backoff_time)) begin
                s_dec = cmc_pkg::DEC_BACKOFF;
            end else if (s_desired != e_mode) begin
                if (reached(r_in_time, e_mea, s_cfg.debounce_time)) begin
                    s_dec  = cmc_pkg::DEC_SWITCHED;
                    n_mode = s_desired;
                    n_mea  = r_in_time;
                    // leaving cooling arms the compressor backoff
                    if (cmc_pkg::compressor_on(e_mode) && !cmc_pkg::compressor_on(s_desired))
                    begin
                        n_cend  = r_in_time;
                        n_armed = 1'b1;
                    end
                    if (s_desired == cmc_pkg::MODE_HIGH) begin
                        n_cstart = r_in_time;
                        n_phase  = 1'b1;
                    end else if (!cmc_pkg::compressor_on(s_desired)) begin
                        n_phase = 1'b0;
                    end
                end else begin
                    s_dec = cmc_pkg::DEC_DEBOUNCE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= cmc_pkg::MODE_OFF;
            r_mea     <= '0;
            r_cstart  <= '0;
            r_cend    <= '0;
            r_phase   <= 1'b0;
            r_armed   <= 1'b0;
            r_started <= 1'b0;
            r_target  <= cmc_pkg::TGT_RESET;
        end else if (s_adv) begin
            r_mode    <= n_mode;
            r_mea     <= n_mea;
            r_cstart  <= n_cstart;
            r_cend    <= n_cend;
            r_phase   <= n_phase;
            r_armed   <= n_armed;
            r_started <= n_started;
            r_target  <= n_target;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv)
            r_out_data <= {7'd0, n_target, s_dec, cmc_pkg::mode_code(n_mode)};
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // cool medium is never entered
    a_no_medium: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode != cmc_pkg::MODE_MED)
        else $error("cool medium entered");

    // target stays clamped
    a_target_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_target >= cmc_pkg::TGT_MIN) && (r_target <= cmc_pkg::TGT_MAX))
        else $error("target out of range");

    // before the first evaluate the block rests off with no backoff
    a_idle_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_mode == cmc_pkg::MODE_OFF) && !r_armed && !r_phase)
        else $error("state changed before start");

    // an adjust never changes the mode
    a_adjust_keeps_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_adv && (r_in_req == cmc_pkg::REQ_ADJUST)) |=> $stable(r_mode))
        else $error("adjust changed mode");

    // a new result is produced only into a free or draining result slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv |-> (!r_out_valid || m_axis_tready))
        else $error("result overwritten");

endmodule

`default_nettype wire

/* tb/cooling_mode_controller_tb.sv */
// self-checking testbench for cooling_mode_controller: directed and random request streams,
// apb register writes between phases and a request-by-request mode predictor with scoreboard
// depends on cmc_pkg and cooling_mode_controller
`default_nettype none

module cooling_mode_controller_tb;

    import cmc_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    // one second in the block's microsecond timestamps
    localparam logic [TW-1:0] SEC = TW'(1_000_000);
    // first evaluate timestamp of the directed part
    localparam logic [TW-1:0] T0 = TW'(1000);
    // request beat to result beat, plus some slack
    localparam int SETTLE_CYCLES = 4;

    // one request as it travels on s_axis
    typedef struct {
        logic                 kind;
        logic [TW-1:0]        stamp;
        logic signed [15:0]   humidex;
        logic signed [11:0]   step;
    } t_request;

    // one result as it travels on m_axis
    typedef struct {
        logic [2:0]  ac_mode;
        logic [1:0]  decision;
        logic [11:0] target_now;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [62:0] now_time, [78:63] humidex sample, [90:79] target_step, [95:91] zero
    logic [95:0] s_axis_tdata = '0;
    // [0] req_type
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [2:0] ac_mode, [4:3] decision, [16:5] target_now, [23:17] zero
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [DATA_WIDTH-1:0] pwdata = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic        pready;

    // stimulus and scoreboard storage
    t_request pending_requests[$];
    t_result  expected_results[$];
    int       mismatch_count = 0;
    // set during the phase where neither side idles
    logic     no_idle = 1'b0;

    // predictor copy of the register file and of the controller state
    t_cfg          active_cfg;
    logic [2:0]    cur_mode;
    logic [TW-1:0] entered_at;
    logic [TW-1:0] cycle_start_at;
    logic [TW-1:0] cycle_end_at;
    logic          in_cycle;
    logic          rest_armed;
    logic          running;
    logic [11:0]   target_hdx;

    // scratch for the clocked blocks
    t_request next_req;
    t_request seen_req;
    t_result  seen_res;
    t_result  want_res;

    cooling_mode_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #10 i_clk = ~i_clk;

    // low, medium and high cooling count as the compressor running
    function automatic logic compressor_on_code(input logic [2:0] m);
        return m == CODE_LOW || m == CODE_MED || m == CODE_HIGH;
    endfunction

    // signed modular elapsed time since 'since' has reached 'limit';
    // a negative elapsed time never reaches anything
    function automatic logic elapsed_reached(input logic [TW-1:0] now,
                                             input logic [TW-1:0] since,
                                             input logic [39:0] limit);
        logic [TW-1:0] span;
        span = now - since;
        if (span[TW-1])
            return 1'b0;
        return span >= TW'(limit);
    endfunction

    // apply one accepted request to the predicted controller state
    function automatic t_result step_controller(input t_request req);
        t_result    res;
        int         delta;
        int         next_target;
        logic       over_cycle;
        logic [2:0] wanted;
        res.decision = DEC_STAY;
        if (req.kind == REQ_ADJUST) begin
            next_target = int'(target_hdx) + int'(req.step);
            if (next_target < int'(TGT_MIN))
                next_target = int'(TGT_MIN);
            if (next_target > int'(TGT_MAX))
                next_target = int'(TGT_MAX);
            target_hdx = next_target[11:0];
            // once running, an adjust makes the debounce already expired
            if (running)
                entered_at = req.stamp - TW'(active_cfg.debounce_time);
        end else begin
            // very first evaluate starts the controller from off
            if (!running) begin
                running      = 1'b1;
                cur_mode     = CODE_OFF;
                entered_at   = req.stamp;
                in_cycle     = 1'b0;
                rest_armed   = 1'b0;
                cycle_end_at = '0;
            end
            delta = int'(req.humidex) - int'(target_hdx);
            // outside a cooling cycle only a zero cycle limit counts as expired
            over_cycle = in_cycle ?
                elapsed_reached(req.stamp, cycle_start_at, active_cfg.cool_cycle_time) :
                (active_cfg.cool_cycle_time == '0);
            wanted = cur_mode;
            case (cur_mode)
                CODE_OFF: begin
                    if (delta > int'(active_cfg.start_margin))
                        wanted = CODE_HIGH;
                end
                CODE_HIGH: begin
                    if (over_cycle)
                        wanted = CODE_FAN;
                    else if (delta <= int'(active_cfg.soft_margin))
                        wanted = CODE_LOW;
                end
                CODE_LOW: begin
                    if (delta > int'(active_cfg.soft_margin) + int'(active_cfg.gentle_hysteresis))
                        wanted = CODE_HIGH;
                    else if (delta <= 0 || over_cycle)
                        wanted = CODE_FAN;
                end
                CODE_FAN: begin
                    if (elapsed_reached(req.stamp, entered_at, active_cfg.fan_time))
                        wanted = CODE_OFF;
                end
                default: ;
            endcase
            // compressor rest after a cooling run holds back re-entry into cooling
            if (compressor_on_code(wanted) && !compressor_on_code(cur_mode) && rest_armed &&
                !elapsed_reached(req.stamp, cycle_end_at, active_cfg.backoff_time)) begin
                wanted       = cur_mode;
                res.decision = DEC_BACKOFF;
            end
            if (wanted != cur_mode) begin
                if (elapsed_reached(req.stamp, entered_at, active_cfg.debounce_time)) begin
                    if (compressor_on_code(cur_mode) && !compressor_on_code(wanted)) begin
                        cycle_end_at = req.stamp;
                        rest_armed   = 1'b1;
                    end
                    cur_mode   = wanted;
                    entered_at = req.stamp;
                    if (wanted == CODE_HIGH) begin
                        cycle_start_at = req.stamp;
                        in_cycle       = 1'b1;
                    end else if (wanted == CODE_FAN || wanted == CODE_OFF) begin
                        in_cycle = 1'b0;
                    end
                    res.decision = DEC_SWITCHED;
                end else begin
                    res.decision = DEC_DEBOUNCE;
                end
            end
        end
        res.ac_mode    = cur_mode;
        res.target_now = target_hdx;
        return res;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic push_item(input logic kind, input logic [TW-1:0] stamp,
                             input int humidex, input int step);
        t_request req;
        req.kind    = kind;
        req.stamp   = stamp;
        req.humidex = humidex[15:0];
        req.step    = step[11:0];
        pending_requests.push_back(req);
    endtask

    // one apb write: setup cycle, then access cycle; pready is tied high in the block
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // the block takes the value at this edge, so does the predictor
        case (idx)
            REG_DEBOUNCE:   active_cfg.debounce_time     = value[39:0];
            REG_COOL_CYCLE: active_cfg.cool_cycle_time   = value[39:0];
            REG_FAN:        active_cfg.fan_time          = value[39:0];
            REG_BACKOFF:    active_cfg.backoff_time      = value[39:0];
            REG_DEADBAND:   active_cfg.start_margin      = value[10:0];
            REG_GENTLE:     active_cfg.soft_margin       = value[10:0];
            REG_HYST:       active_cfg.gentle_hysteresis = value[9:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_settings(input t_cfg c);
        write_reg(REG_DEBOUNCE,   64'(c.debounce_time));
        write_reg(REG_COOL_CYCLE, 64'(c.cool_cycle_time));
        write_reg(REG_FAN,        64'(c.fan_time));
        write_reg(REG_BACKOFF,    64'(c.backoff_time));
        write_reg(REG_DEADBAND,   64'(c.start_margin));
        write_reg(REG_GENTLE,     64'(c.soft_margin));
        write_reg(REG_HYST,       64'(c.gentle_hysteresis));
        @(negedge i_clk);
    endtask

    // sender holds off until every request went out and every result came back
    task automatic wait_for_results();
        do @(negedge i_clk); while (pending_requests.size() != 0 || s_axis_tvalid);
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // random run: mostly a forward-moving clock with steps on the scale of the
    // configured times and samples around the target, plus some noise
    task automatic queue_random_run(input int count, input logic [TW-1:0] scale,
                                    input logic [TW-1:0] origin);
        logic [TW-1:0] clock_now;
        logic [TW-1:0] stamp;
        logic [63:0]   span;
        int            target_guess;
        int            reach;
        int            roll;
        int            sample;
        int            delta_step;
        clock_now    = origin;
        target_guess = int'(target_hdx);
        reach = int'(active_cfg.start_margin) + int'(active_cfg.soft_margin) +
                int'(active_cfg.gentle_hysteresis) + 400;
        span  = {1'b0, scale} * 64'd2 + 64'd2;
        for (int n = 0; n < count; n++) begin
            roll      = $urandom_range(99);
            clock_now = clock_now + TW'(rand64() % span);
            stamp     = clock_now;
            // noise: a wild timestamp or one that runs backwards
            if (roll < 4)
                stamp = TW'(rand64());
            else if (roll < 8)
                stamp = clock_now - TW'(rand64() % span);
            sample = target_guess + int'($urandom_range(0, reach + 400)) - 400;
            if ($urandom_range(9) == 0)
                sample = int'($urandom_range(0, 30000)) - 10000;
            if (sample < -10000)
                sample = -10000;
            if (sample > 20000)
                sample = 20000;
            delta_step = int'($urandom_range(0, 600)) - 300;
            if (roll >= 8 && roll < 10)
                delta_step = int'($urandom_range(0, 4000)) - 2000;
            if (roll >= 8 && roll < 18) begin
                target_guess = target_guess + delta_step;
                if (target_guess < 2000)
                    target_guess = 2000;
                if (target_guess > 4000)
                    target_guess = 4000;
                push_item(REQ_ADJUST, stamp, sample, delta_step);
            end else begin
                push_item(REQ_EVAL, stamp, sample, delta_step);
            end
        end
    endtask

    // request driver: presents the next queued beat, idles now and then
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_requests.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
                next_req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'd0, next_req.step, next_req.humidex, next_req.stamp};
                s_axis_tuser  <= next_req.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result sink: stalls at random outside the steady phase
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(99) >= 11);
        end
    end

    // monitor: predicts on every accepted request beat, checks every result beat
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_res.ac_mode    = m_axis_tdata[2:0];
                seen_res.decision   = m_axis_tdata[4:3];
                seen_res.target_now = m_axis_tdata[16:5];
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, mode %0d decision %0d",
                             $realtime, seen_res.ac_mode, seen_res.decision);
                    mismatch_count++;
                end else begin
                    want_res = expected_results.pop_front();
                    if (seen_res.ac_mode != want_res.ac_mode) begin
                        $display("%0t: ac_mode expected %0d, actual %0d",
                                 $realtime, want_res.ac_mode, seen_res.ac_mode);
                        mismatch_count++;
                    end
                    if (seen_res.decision != want_res.decision) begin
                        $display("%0t: decision expected %0d, actual %0d",
                                 $realtime, want_res.decision, seen_res.decision);
                        mismatch_count++;
                    end
                    if (seen_res.target_now != want_res.target_now) begin
                        $display("%0t: target_now expected %0d, actual %0d",
                                 $realtime, want_res.target_now, seen_res.target_now);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_req.kind    = s_axis_tuser[0];
                seen_req.stamp   = s_axis_tdata[62:0];
                seen_req.humidex = s_axis_tdata[78:63];
                seen_req.step    = s_axis_tdata[90:79];
                expected_results.push_back(step_controller(seen_req));
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin
        #(64'd20 * 64'd500_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        // predictor starts in the reset state of the block
        active_cfg = '{DEBOUNCE_RST, COOL_CYCLE_RST, FAN_RST, BACKOFF_RST,
                       DEADBAND_RST, GENTLE_RST, HYST_RST};
        cur_mode       = CODE_OFF;
        entered_at     = '0;
        cycle_start_at = '0;
        cycle_end_at   = '0;
        in_cycle       = 1'b0;
        rest_armed     = 1'b0;
        running        = 1'b0;
        target_hdx     = TGT_RESET;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk through the default settings
        // adjusts before the first evaluate only move the target, both clamps hit
        push_item(REQ_ADJUST, '0, 0, 2000);
        push_item(REQ_ADJUST, '0, 20000, -2000);
        push_item(REQ_ADJUST, '0, -10000, -2000);
        push_item(REQ_ADJUST, '0, 0, 900);
        // first evaluate starts the controller, coldest sample stays off
        push_item(REQ_EVAL, T0, -10000, 0);
        // hottest sample wants high cooling, debounce holds, then it goes
        push_item(REQ_EVAL, T0 + 30 * SEC, 20000, 0);
        push_item(REQ_EVAL, T0 + 61 * SEC, 20000, 0);
        // inside the gentle band: low is wanted but debounce holds
        push_item(REQ_EVAL, T0 + 70 * SEC, 2950, 0);
        // an adjust after start clears the debounce, so low is entered now
        push_item(REQ_ADJUST, T0 + 70 * SEC, 0, 0);
        push_item(REQ_EVAL, T0 + 70 * SEC, 2950, 0);
        // above gentle band plus hysteresis: back to high after debounce
        push_item(REQ_EVAL, T0 + 71 * SEC, 3030, 0);
        push_item(REQ_EVAL, T0 + 140 * SEC, 3030, 0);
        // cooling cycle limit runs out: fan
        push_item(REQ_EVAL, T0 + 3740 * SEC, 3030, 0);
        push_item(REQ_EVAL, T0 + 3750 * SEC, 20000, 0);
        // fan time over: off
        push_item(REQ_EVAL, T0 + 3930 * SEC, 2900, 0);
        // compressor still resting: blocked by backoff, later allowed
        push_item(REQ_EVAL, T0 + 3935 * SEC, 20000, 0);
        push_item(REQ_EVAL, T0 + 4740 * SEC, 20000, 0);
        // timestamps behind the last switch count as negative elapsed time
        push_item(REQ_EVAL, T0 + 5 * SEC, 2900, 0);
        push_item(REQ_EVAL, {TW{1'b1}}, 20000, -2000);
        push_item(REQ_ADJUST, '0, -10000, 2000);
        push_item(REQ_EVAL, '0, 3900, 2000);
        push_item(REQ_EVAL, '0, 4000, 0);
        wait_for_results();

        // short times with timestamps wrapping past the top of the range
        write_settings('{40'd1000, 40'd20000, 40'd3000, 40'd8000, 11'd300, 11'd100, 10'd25});
        queue_random_run(140, TW'(1500), {TW{1'b1}} - TW'(60000));
        wait_for_results();

        // every register at zero: cycle limit counts as expired outside cooling
        write_settings('{40'd0, 40'd0, 40'd0, 40'd0, 11'd0, 11'd0, 10'd0});
        queue_random_run(140, TW'(50), TW'(rand64()));
        wait_for_results();

        // every time register at its largest value, margins at 2000, hysteresis at 1000
        write_settings('{{40{1'b1}}, {40{1'b1}}, {40{1'b1}}, {40{1'b1}},
                         11'd2000, 11'd2000, 10'd1000});
        queue_random_run(140, TW'({40{1'b1}}), '0);
        wait_for_results();

        // long stretch with both sides always ready
        write_settings('{40'd500, 40'd7000, 40'd1200, 40'd2500, 11'd50, 11'd400, 10'd0});
        no_idle = 1'b1;
        queue_random_run(140, TW'(800), TW'(rand64()));
        wait_for_results();
        no_idle = 1'b0;

        // back to the power-on settings with realistic steps
        write_settings('{DEBOUNCE_RST, COOL_CYCLE_RST, FAN_RST, BACKOFF_RST,
                         DEADBAND_RST, GENTLE_RST, HYST_RST});
        queue_random_run(140, TW'(200_000_000), TW'(rand64()));
        wait_for_results();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_cfg_regs.sv
hw/rtl/cooling_mode_controller.sv
tb/cooling_mode_controller_tb.sv
